>>> rtl/fat12_pkg.sv
// ----------------------------------------------------------------------------
// fat12_pkg
// Shared types and constants of the FAT12 allocation table engine: table
// geometry, item kinds, command and result words, back-end states.
// ----------------------------------------------------------------------------
package fat12_pkg;

   // table geometry
   localparam int MAX_ENTRIES  = 4096;
   localparam int STORE_SIZE   = (MAX_ENTRIES * 3) / 2;
   localparam int BANK_DEPTH   = STORE_SIZE / 2;
   localparam int BANK_AW      = 12;

   // field widths
   localparam int KIND_W       = 2;
   localparam int ADDR_W       = 13;
   localparam int BYTE_W       = 8;
   localparam int CLUS_W       = 12;
   localparam int SECT_W       = 16;
   localparam int LIMIT_W      = 13;

   // queue sizes
   localparam int CQ_AW        = 2;
   localparam int CQ_DEPTH     = 1 << CQ_AW;
   localparam int RQ_AW        = 2;
   localparam int RQ_DEPTH     = 1 << RQ_AW;

   // item kinds on the request port
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd2;

   // register indexes
   localparam logic CSR_DATA_START = 1'b0;
   localparam logic CSR_ENTRIES    = 1'b1;

   // register reset values
   localparam logic [SECT_W-1:0]  DATA_START_RST = 16'd33;
   localparam logic [LIMIT_W-1:0] ENTRIES_RST    = 13'd4096;

   // first cluster of the data area
   localparam logic [CLUS_W-1:0] FIRST_DATA_CLUS = 12'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_READ,
      OP_SCAN
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   byte_address;
      logic [BYTE_W-1:0]   byte_value;
      logic [CLUS_W-1:0]   cluster;
   } cmd_type;

   typedef struct packed {
      logic [CLUS_W-1:0]   entry_value;
      logic                end_of_chain;
      logic [SECT_W-1:0]   sector_index;
      logic [CLUS_W-1:0]   first_free;
      logic [CLUS_W-1:0]   free_total;
      logic                bad_cluster;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_SCAN,
      BK_DRAIN,
      BK_FINISH
   } bk_state_type;

endpackage

>>> rtl/fat12_front.sv
// ----------------------------------------------------------------------------
// fat12_front
// Request side: takes items, sorts them into table writes, entry reads and
// scans, drops the ones that do nothing, and queues commands for the back end.
// ----------------------------------------------------------------------------
module fat12_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [fat12_pkg::KIND_W-1:0]    req_kind,
   input  logic [fat12_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [fat12_pkg::BYTE_W-1:0]    req_byte_value,
   input  logic [fat12_pkg::CLUS_W-1:0]    req_cluster,
   output logic                            cmd_valid,
   output fat12_pkg::cmd_type              cmd_word,
   input  logic                            cmd_pop
);
   import fat12_pkg::*;

   cmd_type          q_ff [CQ_DEPTH];
   logic [CQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CQ_AW:0]   count_ff, count_in;

   logic             keep;
   logic             push;
   cmd_type          new_cmd;

   // classify the incoming word
   always_comb begin
      new_cmd.byte_address = req_byte_address;
      new_cmd.byte_value   = req_byte_value;
      new_cmd.cluster      = req_cluster;
      new_cmd.op           = OP_WRITE;
      keep                 = 1'b0;
      unique case (req_kind)
         KIND_WRITE: begin
            new_cmd.op = OP_WRITE;
            // writes beyond the store are dropped
            keep       = (req_byte_address < ADDR_W'(STORE_SIZE));
         end
         KIND_READ: begin
            new_cmd.op = OP_READ;
            keep       = 1'b1;
         end
         KIND_SCAN: begin
            new_cmd.op = OP_SCAN;
            keep       = 1'b1;
         end
         default: begin
            new_cmd.op = OP_WRITE;
            keep       = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == (CQ_AW+1)'(CQ_DEPTH));
   assign push      = req_push && !req_full && keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (CQ_AW+1)'(push) - (CQ_AW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> rtl/fat12_back.sv
// ----------------------------------------------------------------------------
// fat12_back
// Execution side: holds the table in two byte banks (even and odd offsets),
// carries out writes and entry reads, walks the table for scans, and queues
// result words.
// ----------------------------------------------------------------------------
module fat12_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  fat12_pkg::cmd_type              cmd_word,
   output logic                            cmd_pop,
   input  logic [fat12_pkg::SECT_W-1:0]    data_area_start,
   input  logic [fat12_pkg::LIMIT_W-1:0]   entries_in_use,
   output logic                            rsp_valid,
   output fat12_pkg::rsp_type              rsp_word,
   input  logic                            rsp_take
);
   import fat12_pkg::*;

   // table banks
   logic [BYTE_W-1:0]  even_mem [BANK_DEPTH];
   logic [BYTE_W-1:0]  odd_mem  [BANK_DEPTH];
   logic [BYTE_W-1:0]  even_q_ff;
   logic [BYTE_W-1:0]  odd_q_ff;

   bk_state_type       state_ff, state_in;
   logic [CLUS_W-1:0]  scan_c_ff, scan_c_in;
   logic [CLUS_W-1:0]  first_ff, first_in;
   logic [CLUS_W-1:0]  total_ff, total_in;

   // read stage
   logic               s2_valid_ff;
   logic               s2_scan_ff;
   logic               s2_odd_ff;
   logic [CLUS_W-1:0]  s2_clus_ff;

   // result queue
   rsp_type            rq_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]   rq_wr_ff, rq_rd_ff;
   logic [RQ_AW:0]     rq_count_ff, rq_count_in;
   logic [RQ_AW+1:0]   rq_used;
   logic               room;
   logic               fin_room;

   logic               rd_en;
   logic               wr_en;
   logic [CLUS_W-1:0]  rd_clus;
   logic [ADDR_W-1:0]  rd_off;
   logic [BANK_AW-1:0] half;
   logic [BANK_AW-1:0] even_idx;
   logic [BANK_AW-1:0] wr_idx;

   logic [LIMIT_W-1:0] limit;
   logic               scan_none;
   logic [CLUS_W-1:0]  last_c;

   logic [2*BYTE_W-1:0] word;
   logic [CLUS_W-1:0]   entry;
   logic                read_push;
   logic                fin_push;
   logic                push;
   rsp_type             push_word;

   // scan bound, clamped to the table size
   always_comb begin
      limit     = (entries_in_use > LIMIT_W'(MAX_ENTRIES)) ?
                  LIMIT_W'(MAX_ENTRIES) : entries_in_use;
      scan_none = (limit < LIMIT_W'(3));
      last_c    = CLUS_W'(limit - 1'b1);
   end

   // space in the result queue, counting the read in flight
   assign rq_used  = (RQ_AW+2)'(rq_count_ff) + (RQ_AW+2)'(s2_valid_ff);
   assign room     = (rq_used < (RQ_AW+2)'(RQ_DEPTH));
   assign fin_room = (rq_count_ff < (RQ_AW+1)'(RQ_DEPTH));

   // entry of the read stage
   always_comb begin
      if (s2_odd_ff) begin
         word = {even_q_ff, odd_q_ff};
      end else begin
         word = {odd_q_ff, even_q_ff};
      end
      entry = s2_clus_ff[0] ? word[15:4] : word[11:0];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_pop   = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rd_clus   = cmd_word.cluster;
      scan_c_in = scan_c_ff;
      first_in  = first_ff;
      total_in  = total_ff;
      fin_push  = 1'b0;

      // free entry bookkeeping for scan reads
      if (s2_valid_ff && s2_scan_ff && (entry == '0)) begin
         total_in = total_ff + 1'b1;
         if (first_ff == '0) begin
            first_in = s2_clus_ff;
         end
      end

      unique case (state_ff)
         BK_RUN: begin
            if (cmd_valid) begin
               unique case (cmd_word.op)
                  OP_WRITE: begin
                     cmd_pop = 1'b1;
                     wr_en   = 1'b1;
                  end
                  OP_READ: begin
                     if (room) begin
                        cmd_pop = 1'b1;
                        rd_en   = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     cmd_pop   = 1'b1;
                     scan_c_in = FIRST_DATA_CLUS;
                     first_in  = '0;
                     total_in  = '0;
                     state_in  = scan_none ? BK_FINISH : BK_SCAN;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            rd_en     = 1'b1;
            rd_clus   = scan_c_ff;
            scan_c_in = scan_c_ff + 1'b1;
            if (scan_c_ff == last_c) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (fin_room) begin
               fin_push = 1'b1;
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // byte offset of an entry: cluster + cluster/2
   always_comb begin
      rd_off   = ADDR_W'(rd_clus) + ADDR_W'(rd_clus[CLUS_W-1:1]);
      half     = rd_off[ADDR_W-1:1];
      even_idx = rd_off[0] ? half + 1'b1 : half;
      wr_idx   = cmd_word.byte_address[ADDR_W-1:1];
   end

   // even bank
   always_ff @(posedge clock) begin
      if (wr_en && !cmd_word.byte_address[0]) begin
         even_mem[wr_idx] <= cmd_word.byte_value;
      end
      if (rd_en) begin
         even_q_ff <= even_mem[even_idx];
      end
   end

   // odd bank
   always_ff @(posedge clock) begin
      if (wr_en && cmd_word.byte_address[0]) begin
         odd_mem[wr_idx] <= cmd_word.byte_value;
      end
      if (rd_en) begin
         odd_q_ff <= odd_mem[half];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_RUN;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s2_valid_ff <= rd_en;
      end
   end

   // read stage payload and scan counters
   always_ff @(posedge clock) begin
      s2_scan_ff <= (state_ff == BK_SCAN);
      s2_odd_ff  <= rd_off[0];
      s2_clus_ff <= rd_clus;
      scan_c_ff  <= scan_c_in;
      first_ff   <= first_in;
      total_ff   <= total_in;
   end

   // result word
   always_comb begin
      read_push = s2_valid_ff && !s2_scan_ff;
      push      = read_push || fin_push;
      push_word = '0;
      if (fin_push) begin
         push_word.first_free = first_ff;
         push_word.free_total = total_ff;
      end else begin
         push_word.entry_value  = entry;
         push_word.end_of_chain = (entry[CLUS_W-1:3] == '1);
         push_word.sector_index = data_area_start + SECT_W'(s2_clus_ff)
                                  - SECT_W'(FIRST_DATA_CLUS);
         push_word.bad_cluster  = (s2_clus_ff < FIRST_DATA_CLUS);
      end
   end

   // result queue
   assign rsp_valid   = (rq_count_ff != '0);
   assign rsp_word    = rq_ff[rq_rd_ff];
   assign rq_count_in = rq_count_ff + (RQ_AW+1)'(push) - (RQ_AW+1)'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= push     ? rq_wr_ff + 1'b1 : rq_wr_ff;
         rq_rd_ff    <= rsp_take ? rq_rd_ff + 1'b1 : rq_rd_ff;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rq_ff[rq_wr_ff] <= push_word;
      end
   end

endmodule

>>> rtl/fat12_table_engine.sv
// ----------------------------------------------------------------------------
// fat12_table_engine
// FAT12 allocation table engine: byte loads, entry reads, free-cluster scans.
// ----------------------------------------------------------------------------
// an entry read is registered in the bank read stage, then queued as a result word
// throughput: byte writes and entry reads, one per cycle (both banks read at once),
//   reads only while the result queue has room; a scan holds the back end while it
//   reads clusters 2 to entries_in_use - 1 (clamped to the table, none if under 3), one
//   entry read per cycle, then pushes its result; later words wait; reset clears the
//   queues and sequencer, registers take reset values; table undefined until written
module fat12_table_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [fat12_pkg::KIND_W-1:0]    req_kind,
   input  logic [fat12_pkg::ADDR_W-1:0]    req_byte_address,
   input  logic [fat12_pkg::BYTE_W-1:0]    req_byte_value,
   input  logic [fat12_pkg::CLUS_W-1:0]    req_cluster,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [fat12_pkg::CLUS_W-1:0]    rsp_entry_value,
   output logic                            rsp_end_of_chain,
   output logic [fat12_pkg::SECT_W-1:0]    rsp_sector_index,
   output logic [fat12_pkg::CLUS_W-1:0]    rsp_first_free,
   output logic [fat12_pkg::CLUS_W-1:0]    rsp_free_total,
   output logic                            rsp_bad_cluster,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [fat12_pkg::SECT_W-1:0]    csr_wdata
);
   import fat12_pkg::*;

   logic [SECT_W-1:0]  data_start_ff;
   logic [LIMIT_W-1:0] entries_ff;

   logic               cmd_valid;
   cmd_type            cmd_word;
   logic               cmd_pop;
   logic               rsp_valid;
   rsp_type            rsp_word;
   logic               rsp_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff <= DATA_START_RST;
         entries_ff    <= ENTRIES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DATA_START: data_start_ff <= csr_wdata;
            CSR_ENTRIES:    entries_ff    <= csr_wdata[LIMIT_W-1:0];
            default:        data_start_ff <= data_start_ff;
         endcase
      end
   end

   fat12_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .req_cluster      (req_cluster),
      .cmd_valid        (cmd_valid),
      .cmd_word         (cmd_word),
      .cmd_pop          (cmd_pop)
   );

   fat12_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_word         (cmd_word),
      .cmd_pop          (cmd_pop),
      .data_area_start  (data_start_ff),
      .entries_in_use   (entries_ff),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word),
      .rsp_take         (rsp_take)
   );

   // result port
   assign rsp_empty        = !rsp_valid;
   assign rsp_take         = rsp_pop && rsp_valid;
   assign rsp_entry_value  = rsp_word.entry_value;
   assign rsp_end_of_chain = rsp_word.end_of_chain;
   assign rsp_sector_index = rsp_word.sector_index;
   assign rsp_first_free   = rsp_word.first_free;
   assign rsp_free_total   = rsp_word.free_total;
   assign rsp_bad_cluster  = rsp_word.bad_cluster;

endmodule

>>> rtl/fat12_checker.sv
// ----------------------------------------------------------------------------
// fat12_checker
// Port-level checks of the FAT12 table engine, bound to the top level.
// ----------------------------------------------------------------------------
module fat12_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_full,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [fat12_pkg::CLUS_W-1:0]    rsp_entry_value,
   input  logic                            rsp_end_of_chain,
   input  logic [fat12_pkg::SECT_W-1:0]    rsp_sector_index,
   input  logic [fat12_pkg::CLUS_W-1:0]    rsp_first_free,
   input  logic [fat12_pkg::CLUS_W-1:0]    rsp_free_total,
   input  logic                            rsp_bad_cluster
);
   import fat12_pkg::*;

   // the result queue comes out of reset empty and the request queue not full
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_entry_value)
         && $stable(rsp_sector_index) && $stable(rsp_first_free)
         && $stable(rsp_free_total) && $stable(rsp_bad_cluster)))
      else $error("waiting result word changed");

   // a word is either a read result or a scan result
   a_rsp_form: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_first_free == '0 && rsp_free_total == '0)
         || (rsp_entry_value == '0 && !rsp_end_of_chain
             && rsp_sector_index == '0 && !rsp_bad_cluster)))
      else $error("result word mixes read and scan fields");

   // end of chain agrees with the entry
   a_eoc: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_end_of_chain == (rsp_entry_value[CLUS_W-1:3] == '1)))
      else $error("end of chain flag disagrees with entry");

   // a scan never reports a reserved cluster as free
   a_first_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_first_free != '0) |-> (rsp_first_free >= FIRST_DATA_CLUS
         && rsp_free_total != '0))
      else $error("first free cluster out of range");

endmodule

bind fat12_table_engine fat12_checker u_fat12_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_entry_value  (rsp_entry_value),
   .rsp_end_of_chain (rsp_end_of_chain),
   .rsp_sector_index (rsp_sector_index),
   .rsp_first_free   (rsp_first_free),
   .rsp_free_total   (rsp_free_total),
   .rsp_bad_cluster  (rsp_bad_cluster)
);

>>> verif/fat12_table_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_table_engine_test
// Self-checking bench for the FAT12 table engine. A directed table loads a
// few table bytes and reads back entries at the extremes (reserved clusters,
// end-of-chain marks, last cluster, sector wrap), then short scans. Random
// phases follow with the low part of the table loaded first, mixing byte
// writes, entry reads and scans under several register settings and idle
// patterns. Every result word is checked field by field against the values
// given in the directed table or against a local table image.
// ----------------------------------------------------------------------------
module fat12_table_engine_test;
   import fat12_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [CLUS_W-1:0] EOC_FIRST   = 12'hFF8;
   localparam int PHASE_ITEMS   = 330;
   localparam int SETTLE_CYCLES = 16;
   // clusters whose table bytes the first random phase loads
   localparam int LOAD_CLUS     = 256;
   localparam int LOAD_BYTES    = (LOAD_CLUS * 3) / 2;

   // one row of the directed table: a register write or a request word
   typedef struct packed {
      logic                is_csr;
      logic                csr_idx;
      logic [SECT_W-1:0]   csr_val;
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   val;
      logic [CLUS_W-1:0]   clus;
      logic                typed;
      rsp_type             given;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [ADDR_W-1:0]   req_byte_address = '0;
   logic [BYTE_W-1:0]   req_byte_value = '0;
   logic [CLUS_W-1:0]   req_cluster = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [CLUS_W-1:0]   rsp_entry_value;
   logic                rsp_end_of_chain;
   logic [SECT_W-1:0]   rsp_sector_index;
   logic [CLUS_W-1:0]   rsp_first_free;
   logic [CLUS_W-1:0]   rsp_free_total;
   logic                rsp_bad_cluster;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [SECT_W-1:0]   csr_wdata = '0;

   // local image of the table and the registers
   logic [BYTE_W-1:0]   table_img [0:STORE_SIZE-1];
   logic [SECT_W-1:0]   data_start_reg = DATA_START_RST;
   logic [LIMIT_W-1:0]  entry_limit_reg = ENTRIES_RST;

   rsp_type             answers_due [$];
   int                  mismatch_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;

   fat12_table_engine u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_byte_address (req_byte_address),
      .req_byte_value   (req_byte_value),
      .req_cluster      (req_cluster),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_end_of_chain (rsp_end_of_chain),
      .rsp_sector_index (rsp_sector_index),
      .rsp_first_free   (rsp_first_free),
      .rsp_free_total   (rsp_free_total),
      .rsp_bad_cluster  (rsp_bad_cluster),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // 12-bit entry from the little-endian word at cluster*3/2
   function automatic logic [CLUS_W-1:0] entry_of(input int c);
      int off;
      logic [15:0] word;
      off = (c * 3) / 2;
      word = {table_img[(off + 1) % STORE_SIZE], table_img[off % STORE_SIZE]};
      return (c % 2 == 0) ? word[11:0] : word[15:4];
   endfunction

   // applies one request word to the image, returns 1 when a result is due
   function automatic logic compute_answer(input logic [KIND_W-1:0] k,
                                           input logic [ADDR_W-1:0] a,
                                           input logic [BYTE_W-1:0] v,
                                           input logic [CLUS_W-1:0] c,
                                           output rsp_type ans);
      logic has;
      int top;
      int n;
      ans = '0;
      has = 1'b0;
      case (k)
         OP_WRITE: begin
            if (a < STORE_SIZE) table_img[a] = v;
         end
         OP_READ: begin
            has = 1'b1;
            ans.entry_value  = entry_of(c);
            ans.end_of_chain = (ans.entry_value >= EOC_FIRST);
            ans.sector_index = data_start_reg + {4'd0, c} - {4'd0, FIRST_DATA_CLUS};
            ans.bad_cluster  = (c < FIRST_DATA_CLUS);
         end
         OP_SCAN: begin
            has = 1'b1;
            top = (entry_limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit_reg;
            for (n = FIRST_DATA_CLUS; n < top; n++) begin
               if (entry_of(n) == '0) begin
                  if (ans.first_free == '0) ans.first_free = CLUS_W'(n);
                  ans.free_total = ans.free_total + 1'b1;
               end
            end
         end
         default: has = 1'b0;
      endcase
      return has;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
   endtask

   // result side: random stalls, compare each word with the oldest expectation
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_words
      rsp_type due;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_entry_value, 0);
         end else begin
            due = answers_due.pop_front();
            if (rsp_entry_value !== due.entry_value)
               report_mismatch("entry_value", rsp_entry_value, due.entry_value);
            if (rsp_end_of_chain !== due.end_of_chain)
               report_mismatch("end_of_chain", rsp_end_of_chain, due.end_of_chain);
            if (rsp_sector_index !== due.sector_index)
               report_mismatch("sector_index", rsp_sector_index, due.sector_index);
            if (rsp_first_free !== due.first_free)
               report_mismatch("first_free", rsp_first_free, due.first_free);
            if (rsp_free_total !== due.free_total)
               report_mismatch("free_total", rsp_free_total, due.free_total);
            if (rsp_bad_cluster !== due.bad_cluster)
               report_mismatch("bad_cluster", rsp_bad_cluster, due.bad_cluster);
         end
      end
   end

   // request side: called at a falling edge, returns at the falling edge
   // after the word was taken
   task automatic send_word(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                            input logic [BYTE_W-1:0] v, input logic [CLUS_W-1:0] c,
                            input logic typed, input rsp_type given);
      rsp_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push         <= 1'b1;
      req_kind         <= k;
      req_byte_address <= a;
      req_byte_value   <= v;
      req_cluster      <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (compute_answer(k, a, v, c, ans)) answers_due.push_back(typed ? given : ans);
      @(negedge clock);
   endtask

   // wait for every result, then let any trailing byte writes drain
   task automatic settle();
      req_push <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [SECT_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DATA_START) data_start_reg = d;
      else entry_limit_reg = d[LIMIT_W-1:0];
      @(negedge clock);
   endtask

   // byte values leaning to zero and all-ones so free and end-of-chain
   // entries show up often
   function automatic logic [BYTE_W-1:0] table_byte();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 8'h00;
      if (p < 60) return 8'hFF;
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic plan_row_type item_row(input logic [KIND_W-1:0] k,
                                             input logic [ADDR_W-1:0] a,
                                             input logic [BYTE_W-1:0] v,
                                             input logic [CLUS_W-1:0] c);
      plan_row_type r;
      r = '0;
      r.kind = k;
      r.addr = a;
      r.val  = v;
      r.clus = c;
      return r;
   endfunction

   function automatic plan_row_type read_row(input logic [CLUS_W-1:0] c,
                                             input logic [CLUS_W-1:0] e,
                                             input logic eoc,
                                             input logic [SECT_W-1:0] s,
                                             input logic bad);
      plan_row_type r;
      r = item_row(OP_READ, '0, '0, c);
      r.typed = 1'b1;
      r.given.entry_value  = e;
      r.given.end_of_chain = eoc;
      r.given.sector_index = s;
      r.given.bad_cluster  = bad;
      return r;
   endfunction

   function automatic plan_row_type scan_row(input logic [CLUS_W-1:0] f,
                                             input logic [CLUS_W-1:0] t);
      plan_row_type r;
      r = item_row(OP_SCAN, '0, '0, '0);
      r.typed = 1'b1;
      r.given.first_free = f;
      r.given.free_total = t;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic idx, input logic [SECT_W-1:0] d);
      plan_row_type r;
      r = '0;
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = d;
      return r;
   endfunction

   // one random phase; the first one loads the low part of the table, and
   // reads and scans stay on loaded bytes, since a read of a byte never
   // written is outside what the block promises
   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic [SECT_W-1:0] start,
                            input logic [LIMIT_W-1:0] lim, input logic load_all);
      int counted;
      int pick;
      int n;
      logic [ADDR_W-1:0] a;
      logic [CLUS_W-1:0] c;
      settle();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_csr(CSR_DATA_START, start);
      write_csr(CSR_ENTRIES, {3'd0, lim});
      if (load_all) begin
         for (n = 0; n < LOAD_BYTES; n++)
            send_word(OP_WRITE, ADDR_W'(n), table_byte(),
                      CLUS_W'($urandom_range(4095)), 1'b0, '0);
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 44) begin
            // mostly inside the store, now and then beyond it
            a = ($urandom_range(99) < 85) ? ADDR_W'($urandom_range(STORE_SIZE - 1))
                                          : ADDR_W'($urandom_range(8191));
            send_word(OP_WRITE, a, table_byte(), CLUS_W'($urandom_range(4095)),
                      1'b0, '0);
            if (a < STORE_SIZE) counted++;
         end else if (pick < 86) begin
            // reserved clusters now and then, the two top clusters rarely,
            // otherwise the loaded part of the table
            pick = $urandom_range(19);
            if (pick < 2) c = CLUS_W'($urandom_range(1));
            else if (pick < 3) c = CLUS_W'($urandom_range(4095, 4094));
            else c = CLUS_W'($urandom_range(LOAD_CLUS - 1));
            send_word(OP_READ, ADDR_W'($urandom_range(8191)),
                      BYTE_W'($urandom_range(255)), c, 1'b0, '0);
            counted++;
         end else if (pick < 94) begin
            send_word(OP_SCAN, ADDR_W'($urandom_range(8191)),
                      BYTE_W'($urandom_range(255)),
                      CLUS_W'($urandom_range(4095)), 1'b0, '0);
            counted++;
         end else begin
            send_word(KIND_UNUSED, ADDR_W'($urandom_range(8191)),
                      BYTE_W'($urandom_range(255)),
                      CLUS_W'($urandom_range(4095)), 1'b0, '0);
         end
      end
   endtask

   initial begin : main_flow
      plan_row_type plan [$];
      plan_row_type r;
      int i;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // clusters 0 and 1 hold 0xFF8 / 0xFFF, cluster 2 just below the
      // end-of-chain range, cluster 3 free, top two clusters loaded
      plan.push_back(item_row(OP_WRITE, 13'd0, 8'hF8, '0));
      plan.push_back(item_row(OP_WRITE, 13'd1, 8'hFF, '0));
      plan.push_back(item_row(OP_WRITE, 13'd2, 8'hFF, '0));
      plan.push_back(item_row(OP_WRITE, 13'd3, 8'hF7, '0));
      plan.push_back(item_row(OP_WRITE, 13'd4, 8'h0F, '0));
      plan.push_back(item_row(OP_WRITE, 13'd5, 8'h00, '0));
      plan.push_back(item_row(OP_WRITE, 13'd6141, 8'h7F, '0));
      plan.push_back(item_row(OP_WRITE, 13'd6142, 8'hAB, '0));
      plan.push_back(item_row(OP_WRITE, 13'd6143, 8'hCD, '0));
      // beyond the store, dropped
      plan.push_back(item_row(OP_WRITE, 13'd8191, 8'h55, '0));
      // register values from reset
      plan.push_back(read_row(12'd0, 12'hFF8, 1'b1, 16'd31, 1'b1));
      plan.push_back(read_row(12'd1, 12'hFFF, 1'b1, 16'd32, 1'b1));
      plan.push_back(read_row(12'd2, 12'hFF7, 1'b0, 16'd33, 1'b0));
      plan.push_back(read_row(12'd3, 12'h000, 1'b0, 16'd34, 1'b0));
      plan.push_back(read_row(12'd4095, 12'hCDA, 1'b0, 16'd4126, 1'b0));
      plan.push_back(item_row(OP_READ, 13'd8191, 8'hFF, 12'd4094));
      plan.push_back(item_row(KIND_UNUSED, 13'd8191, 8'hFF, 12'hFFF));
      // sector index wraps both ways
      plan.push_back(csr_row(CSR_DATA_START, 16'hFFFF));
      plan.push_back(read_row(12'd0, 12'hFF8, 1'b1, 16'd65533, 1'b1));
      plan.push_back(read_row(12'd4095, 12'hCDA, 1'b0, 16'd4092, 1'b0));
      plan.push_back(csr_row(CSR_DATA_START, 16'h0000));
      plan.push_back(read_row(12'd1, 12'hFFF, 1'b1, 16'd65535, 1'b1));
      // scan covering nothing, then clusters 2 and 3
      plan.push_back(csr_row(CSR_ENTRIES, 16'd2));
      plan.push_back(scan_row(12'd0, 12'd0));
      plan.push_back(csr_row(CSR_ENTRIES, 16'd4));
      plan.push_back(scan_row(12'd3, 12'd1));

      for (i = 0; i < plan.size(); i++) begin
         r = plan[i];
         if (r.is_csr) begin
            settle();
            write_csr(r.csr_idx, r.csr_val);
         end else begin
            send_word(r.kind, r.addr, r.val, r.clus, r.typed, r.given);
         end
      end

      run_phase(0, 0, 16'hFFFF, LIMIT_W'(LOAD_CLUS), 1'b1);
      run_phase(80, 0, SECT_W'($urandom_range(65535)), 13'd2, 1'b0);
      run_phase(0, 80, 16'h0000, LIMIT_W'($urandom_range(LOAD_CLUS, 3)), 1'b0);
      run_phase(7, 7, SECT_W'($urandom_range(65535)),
                LIMIT_W'($urandom_range(LOAD_CLUS, 3)), 1'b0);

      settle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
